// File: rtl/mis_pkg.sv
// ----------------------------------------------------------------------------
// mis_pkg
// Shared constants and types of the multi-hart issue stage.
// ----------------------------------------------------------------------------
`default_nettype none

package mis_pkg;

    // Registers per hart and the width of a register number
    localparam int REGISTERS = 32;
    localparam int REG_W     = 5;

    // Defaults of the top-level parameters
    localparam int HARTS_DEFAULT    = 4;
    localparam int PC_WIDTH_DEFAULT = 16;

    // Field widths fixed by the ports
    localparam int PC_PORT_W = 16;
    localparam int DATA_W    = 32;
    localparam int MASK_W    = 4;

    // Issue result without the register values
    typedef struct packed {
        logic                 issue_valid;
        logic [1:0]           issue_hart;
        logic [PC_PORT_W-1:0] issue_pc;
        logic [DATA_W-1:0]    issue_payload;
        logic [REG_W-1:0]     issue_dest;
        logic                 lock_valid;
        logic [MASK_W-1:0]    full_mask;
    } issue_meta_t;

endpackage : mis_pkg

`default_nettype wire

// File: rtl/multihart_issue_stage.sv
// ----------------------------------------------------------------------------
// multihart_issue_stage
// Issue stage with per-hart instruction buffers, register files and locks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one transfer's worth of stage
//   inputs: an optional decoded instruction, the execute-slot occupancy and
//   an optional register write-back. Output channel (out_valid / out_ready)
//   returns exactly one issue result per input transfer, in order.
//   Timing: results are registered at the input transfer. Throughput: one
//   transfer per cycle while in_ready is high. Hart selection, lock test and
//   buffer update take one pass of logic; the register file is a memory with
//   two registered read ports and one write port, read at the transfer edge.
//   Reset: all buffers empty, all locks clear, every register reads zero
//   (per-entry valid flops, so no clearing pass is needed).
//   Stall: when out_ready is low the pending result holds; one more input
//   transfer is taken while the waiting result moves to a skid register,
//   then in_ready drops until the receiver takes a result.
// ----------------------------------------------------------------------------
`default_nettype none

module multihart_issue_stage #(
    parameter int HARTS    = mis_pkg::HARTS_DEFAULT,
    parameter int PC_WIDTH = mis_pkg::PC_WIDTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          dec_valid,
    input  wire logic [1:0]                    dec_hart,
    input  wire logic [mis_pkg::PC_PORT_W-1:0] dec_pc,
    input  wire logic [mis_pkg::REG_W-1:0]     dec_src1,
    input  wire logic [mis_pkg::REG_W-1:0]     dec_src2,
    input  wire logic [mis_pkg::REG_W-1:0]     dec_dest,
    input  wire logic [1:0]                    src_used,
    input  wire logic [mis_pkg::DATA_W-1:0]    dec_payload,
    input  wire logic [mis_pkg::MASK_W-1:0]    exec_full_mask,
    input  wire logic                          wb_valid,
    input  wire logic [6:0]                    wb_slot,
    input  wire logic signed [mis_pkg::DATA_W-1:0] wb_value,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               issue_valid,
    output logic [1:0]                         issue_hart,
    output logic signed [mis_pkg::DATA_W-1:0]  src_value_1,
    output logic signed [mis_pkg::DATA_W-1:0]  src_value_2,
    output logic [mis_pkg::PC_PORT_W-1:0]      issue_pc,
    output logic [mis_pkg::DATA_W-1:0]         issue_payload,
    output logic [mis_pkg::REG_W-1:0]          issue_dest,
    output logic                               lock_valid,
    output logic [mis_pkg::MASK_W-1:0]         full_mask
);

    import mis_pkg::*;

    localparam int HW      = $clog2(HARTS);
    localparam int SW      = HW + REG_W;
    localparam int SLOTS   = HARTS * REGISTERS;
    localparam int PC_KEEP = (PC_WIDTH < PC_PORT_W) ? PC_WIDTH : PC_PORT_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic                  full_reg    [HARTS];
    logic [PC_KEEP-1:0]    buf_pc_reg  [HARTS];
    logic [REG_W-1:0]      buf_src1_reg[HARTS];
    logic [REG_W-1:0]      buf_src2_reg[HARTS];
    logic [REG_W-1:0]      buf_dest_reg[HARTS];
    logic [1:0]            buf_used_reg[HARTS];
    logic [DATA_W-1:0]     buf_pay_reg [HARTS];

    logic                  lock_reg    [SLOTS];
    logic                  rf_ok_reg   [SLOTS];
    logic [DATA_W-1:0]     rf_mem      [SLOTS];

    // Result register (read data comes straight from the memory ports)
    logic                  r_valid_reg;
    issue_meta_t           r_meta_reg;
    logic [DATA_W-1:0]     rd1_reg;
    logic [DATA_W-1:0]     rd2_reg;
    logic                  rd1_ok_reg;
    logic                  rd2_ok_reg;

    // Skid register
    logic                  k_valid_reg;
    issue_meta_t           k_meta_reg;
    logic [DATA_W-1:0]     k_src1_reg;
    logic [DATA_W-1:0]     k_src2_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_acc;

    assign in_ready = !k_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;

    // ------------------------------------------------------------------
    // Ready test and lowest-hart selection
    // ------------------------------------------------------------------
    logic          hart_rdy[HARTS];
    logic          found;
    logic [HW-1:0] win;

    always_comb
    begin
        for (int h = 0; h < HARTS; h++)
        begin
            logic busy_x;
            logic busy1;
            logic busy2;
            busy_x = 1'b0;
            if (h < MASK_W)
                busy_x = exec_full_mask[2'(h)];
            busy1 = buf_used_reg[h][0] && lock_reg[{HW'(h), buf_src1_reg[h]}];
            busy2 = buf_used_reg[h][1] && lock_reg[{HW'(h), buf_src2_reg[h]}];
            hart_rdy[h] = full_reg[h] && !busy_x && !busy1 && !busy2;
        end
        found = 1'b0;
        win   = '0;
        for (int h = HARTS - 1; h >= 0; h--)
        begin
            if (hart_rdy[h])
            begin
                found = 1'b1;
                win   = HW'(h);
            end
        end
    end

    // ------------------------------------------------------------------
    // Decode write-back and arrival targets
    // ------------------------------------------------------------------
    logic          wb_hit;
    logic          wb_write;
    logic [SW-1:0] wb_idx;
    logic          arr_hit;
    logic [HW-1:0] arr_hart;
    logic          lock_set;
    logic [SW-1:0] lock_idx;
    logic [SW-1:0] rd_idx1;
    logic [SW-1:0] rd_idx2;

    assign wb_hit   = wb_valid && (int'(wb_slot[6:5]) < HARTS);
    assign wb_write = wb_hit && (wb_slot[4:0] != '0);
    assign wb_idx   = {HW'(wb_slot[6:5]), wb_slot[4:0]};
    assign arr_hit  = dec_valid && (int'(dec_hart) < HARTS);
    assign arr_hart = HW'(dec_hart);
    assign lock_set = found && (buf_dest_reg[win] != '0);
    assign lock_idx = {win, buf_dest_reg[win]};
    assign rd_idx1  = {win, buf_src1_reg[win]};
    assign rd_idx2  = {win, buf_src2_reg[win]};

    // ------------------------------------------------------------------
    // Buffer occupancy after this cycle
    // ------------------------------------------------------------------
    logic              full_next[HARTS];
    logic [MASK_W-1:0] mask_next;

    always_comb
    begin
        mask_next = '0;
        for (int h = 0; h < HARTS; h++)
        begin
            full_next[h] = full_reg[h];
            if (found && (win == HW'(h)))
                full_next[h] = 1'b0;
            if (arr_hit && (arr_hart == HW'(h)))
                full_next[h] = 1'b1;
            if (h < MASK_W)
                mask_next[2'(h)] = full_next[h];
        end
    end

    // ------------------------------------------------------------------
    // Issue result fields, zero but for the full mask when nothing issues
    // ------------------------------------------------------------------
    issue_meta_t meta_next;

    always_comb
    begin
        meta_next             = '0;
        meta_next.full_mask   = mask_next;
        if (found)
        begin
            meta_next.issue_valid   = 1'b1;
            meta_next.issue_hart    = 2'(win);
            meta_next.issue_pc      = PC_PORT_W'(buf_pc_reg[win]);
            meta_next.issue_payload = buf_pay_reg[win];
            meta_next.issue_dest    = buf_dest_reg[win];
            meta_next.lock_valid    = lock_set;
        end
    end

    // ------------------------------------------------------------------
    // Buffer full flags
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < HARTS; h++)
                full_reg[h] <= 1'b0;
        end
        else if (in_acc)
        begin
            for (int h = 0; h < HARTS; h++)
                full_reg[h] <= full_next[h];
        end
    end

    // Fill the arriving hart's buffer, overwriting it
    always_ff @(posedge clk)
    begin
        if (in_acc && arr_hit)
        begin
            buf_pc_reg[arr_hart]   <= dec_pc[PC_KEEP-1:0];
            buf_src1_reg[arr_hart] <= dec_src1;
            buf_src2_reg[arr_hart] <= dec_src2;
            buf_dest_reg[arr_hart] <= dec_dest;
            buf_used_reg[arr_hart] <= src_used;
            buf_pay_reg[arr_hart]  <= dec_payload;
        end
    end

    // ------------------------------------------------------------------
    // Locks: write-back clears, then the issue lock sets
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
                lock_reg[s] <= 1'b0;
        end
        else if (in_acc)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (lock_set && (lock_idx == SW'(s)))
                    lock_reg[s] <= 1'b1;
                else if (wb_hit && (wb_idx == SW'(s)))
                    lock_reg[s] <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register file: written-entry flags, memory, registered reads
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
                rf_ok_reg[s] <= 1'b0;
            rd1_ok_reg <= 1'b0;
            rd2_ok_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            rd1_ok_reg <= rf_ok_reg[rd_idx1];
            rd2_ok_reg <= rf_ok_reg[rd_idx2];
            if (wb_write)
                rf_ok_reg[wb_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd1_reg <= rf_mem[rd_idx1];
            rd2_reg <= rf_mem[rd_idx2];
            if (wb_write)
                rf_mem[wb_idx] <= wb_value;
        end
    end

    // ------------------------------------------------------------------
    // Result register and skid register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_src1;
    logic [DATA_W-1:0] r_src2;

    assign r_src1 = (r_meta_reg.issue_valid && rd1_ok_reg) ? rd1_reg : '0;
    assign r_src2 = (r_meta_reg.issue_valid && rd2_ok_reg) ? rd2_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
                r_valid_reg <= 1'b1;
            else if (out_acc && !k_valid_reg)
                r_valid_reg <= 1'b0;

            if (in_acc && r_valid_reg && !out_ready)
                k_valid_reg <= 1'b1;
            else if (out_acc)
                k_valid_reg <= 1'b0;
        end
    end

    // Load the new result; park the waiting one in the skid register
    always_ff @(posedge clk)
    begin
        if (in_acc)
            r_meta_reg <= meta_next;
        if (in_acc && r_valid_reg && !out_ready)
        begin
            k_meta_reg <= r_meta_reg;
            k_src1_reg <= r_src1;
            k_src2_reg <= r_src2;
        end
    end

    // ------------------------------------------------------------------
    // Output select: skid entry is older
    // ------------------------------------------------------------------
    issue_meta_t       o_meta;
    logic [DATA_W-1:0] o_src1;
    logic [DATA_W-1:0] o_src2;

    assign o_meta = k_valid_reg ? k_meta_reg : r_meta_reg;
    assign o_src1 = k_valid_reg ? k_src1_reg : r_src1;
    assign o_src2 = k_valid_reg ? k_src2_reg : r_src2;

    assign out_valid     = k_valid_reg || r_valid_reg;
    assign issue_valid   = o_meta.issue_valid;
    assign issue_hart    = o_meta.issue_hart;
    assign src_value_1   = $signed(o_src1);
    assign src_value_2   = $signed(o_src2);
    assign issue_pc      = o_meta.issue_pc;
    assign issue_payload = o_meta.issue_payload;
    assign issue_dest    = o_meta.issue_dest;
    assign lock_valid    = o_meta.lock_valid;
    assign full_mask     = o_meta.full_mask;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_win_full: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> full_reg[win])
        else $error("selected hart has an empty buffer");

    a_lock_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && lock_set) |=> lock_reg[$past(lock_idx)])
        else $error("issued destination is not locked");

    a_lock_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && issue_valid) |-> (lock_valid == (issue_dest != '0)))
        else $error("lock flag disagrees with destination");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !issue_valid) |->
            (issue_pc == '0 && issue_dest == '0 && !lock_valid && src_value_1 == '0))
        else $error("no-issue result carries nonzero fields");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        k_valid_reg |-> r_valid_reg)
        else $error("skid entry without a newer result behind it");

endmodule : multihart_issue_stage

`default_nettype wire
